[rtl/core/imhq_pkg.sv]
// Shared types and constants for the indexed min-heap queue.
`default_nettype none

package imhq_pkg;

  localparam int ID_W      = 8;
  localparam int ID_SPACE  = 256;
  localparam int CNT_W     = 9;
  localparam int KEY_IN_W  = 32;
  localparam int MAX_DEPTH = 256;
  localparam int LVL_W     = 4;
  localparam int OFF_W     = 8;
  localparam int PAIR_W    = OFF_W - 1;
  localparam int MAP_W     = LVL_W + OFF_W;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CHANGE = 2'd2,
    OP_PEEK   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_ABSENT = 3'd2,
    ST_DUP    = 3'd3,
    ST_EMPTY  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    SRC_TOKEN,
    SRC_ABOVE,
    SRC_BELOW
  } wr_src_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAP_DATA,
    S_LAST_DATA,
    S_OLD_DATA,
    S_UP_RD,
    S_UP_CMP,
    S_DOWN_RD,
    S_DOWN_CMP,
    S_PLACE,
    S_ROOT_RD,
    S_ROOT_DATA
  } state_t;

  // Broadcast to every level cell; only the addressed level acts.
  typedef struct packed {
    logic              rd_en;
    logic [LVL_W-1:0]  rd_level;
    logic [PAIR_W-1:0] rd_pair;
    logic              wr_en;
    logic [LVL_W-1:0]  wr_level;
    logic [PAIR_W-1:0] wr_pair;
    logic              wr_bank;
    wr_src_t           wr_src;
    logic              nb_bank;
  } cell_req_t;

endpackage

`default_nettype wire

[rtl/core/imhq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module imhq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/imhq_cell.sv]
// One heap level: even/odd sibling banks plus neighbor hand-off on writes.
`default_nettype none

module imhq_cell #(
  parameter int LEVEL = 0,
  parameter int PAIRS = 1,
  parameter int KEY_W = 32,
  localparam int SW = imhq_pkg::ID_W + KEY_W,
  localparam int AW = (PAIRS > 1) ? $clog2(PAIRS) : 1
) (
  input  logic                      clk,
  input  imhq_pkg::cell_req_t       req,
  input  logic [imhq_pkg::ID_W-1:0] token_id,
  input  logic [KEY_W-1:0]          token_key,
  input  logic [2*SW-1:0]           above_pair,
  input  logic [2*SW-1:0]           below_pair,
  output logic [2*SW-1:0]           pair_out
);

  logic          sel_rd;
  logic          sel_wr;
  logic [2*SW-1:0] nb_pair;
  logic [SW-1:0] nb_slot;
  logic [SW-1:0] wr_slot;

  assign sel_rd = req.rd_en && (req.rd_level == imhq_pkg::LVL_W'(LEVEL));
  assign sel_wr = req.wr_en && (req.wr_level == imhq_pkg::LVL_W'(LEVEL));

  // parent moving down comes from the level above, child moving up from below
  assign nb_pair = (req.wr_src == imhq_pkg::SRC_ABOVE) ? above_pair : below_pair;
  assign nb_slot = req.nb_bank ? nb_pair[2*SW-1:SW] : nb_pair[SW-1:0];

  always_comb begin
    case (req.wr_src)
      imhq_pkg::SRC_TOKEN: wr_slot = {token_id, token_key};
      imhq_pkg::SRC_ABOVE: wr_slot = nb_slot;
      imhq_pkg::SRC_BELOW: wr_slot = nb_slot;
      default:             wr_slot = {token_id, token_key};
    endcase
  end

  imhq_ram #(.WIDTH(SW), .DEPTH(PAIRS)) u_even (
    .clk     (clk),
    .wr_en   (sel_wr && !req.wr_bank),
    .wr_addr (req.wr_pair[AW-1:0]),
    .wr_data (wr_slot),
    .rd_en   (sel_rd),
    .rd_addr (req.rd_pair[AW-1:0]),
    .rd_data (pair_out[SW-1:0])
  );

  imhq_ram #(.WIDTH(SW), .DEPTH(PAIRS)) u_odd (
    .clk     (clk),
    .wr_en   (sel_wr && req.wr_bank),
    .wr_addr (req.wr_pair[AW-1:0]),
    .wr_data (wr_slot),
    .rd_en   (sel_rd),
    .rd_addr (req.rd_pair[AW-1:0]),
    .rd_data (pair_out[2*SW-1:SW])
  );

endmodule

`default_nettype wire

[rtl/core/indexed_min_heap_queue_unit.sv]
// Indexed binary min-heap queue: top level, sequencer and level-cell row.
// Refused requests and peek go straight to the root read; a sift walks the
// heap one level at a time, up or down. One request at a time.
// Reset: item count zero, all present bits clear, capacity_limit 256; heap and
// position memories are not cleared, so no clearing pass is needed.
`default_nettype none

module indexed_min_heap_queue_unit #(
  parameter int CAPACITY  = 256,
  parameter int KEY_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [7:0]  item_id,
  input  logic [31:0] key,
  output logic        done,
  output logic [2:0]  status,
  output logic        top_valid,
  output logic [7:0]  top_item,
  output logic [31:0] top_key,
  output logic [8:0]  count,
  input  logic        cfg_wr_en,
  input  logic [8:0]  cfg_wr_data
);

  // Ids are 8 bits, so the heap never holds more than 256 items.
  localparam int HEAP_DEPTH = (CAPACITY < imhq_pkg::MAX_DEPTH) ? CAPACITY
                                                               : imhq_pkg::MAX_DEPTH;
  localparam int LEVELS = $clog2(HEAP_DEPTH + 1);
  localparam int KW     = (KEY_WIDTH < imhq_pkg::KEY_IN_W) ? KEY_WIDTH
                                                           : imhq_pkg::KEY_IN_W;
  localparam int SW     = imhq_pkg::ID_W + KW;
  localparam int CNT_W  = imhq_pkg::CNT_W;
  localparam int LVL_W  = imhq_pkg::LVL_W;
  localparam int OFF_W  = imhq_pkg::OFF_W;
  localparam logic [CNT_W-1:0] LIMIT_CAP = CNT_W'((CAPACITY < 511) ? CAPACITY : 511);

  // Sibling pairs held by one level cell.
  function automatic int level_pairs(input int lvl);
    int first;
    int nodes;
    first = (1 << lvl) - 1;
    nodes = HEAP_DEPTH - first;
    if (nodes > (1 << lvl)) begin
      nodes = 1 << lvl;
    end
    return (nodes + 1) >> 1;
  endfunction

  // ---------------------------------------------------------------- state
  imhq_pkg::state_t  state, state_next;
  imhq_pkg::op_t     op_q;
  imhq_pkg::status_t status_q;

  logic [CNT_W-1:0]            item_count;
  logic [LVL_W-1:0]            tail_level;   // slot of the next free position
  logic [OFF_W-1:0]            tail_off;
  logic [imhq_pkg::ID_SPACE-1:0] present;
  logic [CNT_W-1:0]            cap_limit;

  // sifting token and its cursor (level, offset within level)
  logic [imhq_pkg::ID_W-1:0]   tok_id;
  logic [KW-1:0]               tok_key;
  logic [LVL_W-1:0]            cur_level;
  logic [OFF_W-1:0]            cur_off;
  logic                        fallback;     // removal: no upward move yet, go down
  logic                        right_ok;

  // which level/bank the last heap read targeted
  logic [LVL_W-1:0]            rdq_level;
  logic                        rdq_bank;

  // ---------------------------------------------------------------- helpers
  logic                        accept;
  logic                        here;
  logic [CNT_W-1:0]            limit_eff;
  logic                        ins_ok;
  logic [CNT_W-1:0]            row_last;
  logic [CNT_W-1:0]            dec_row;
  logic [LVL_W-1:0]            tail_dec_level;
  logic [OFF_W-1:0]            tail_dec_off;
  logic [LVL_W-1:0]            tail_inc_level;
  logic [OFF_W-1:0]            tail_inc_off;
  logic [imhq_pkg::MAP_W-1:0]  map_rd_data;
  logic [LVL_W-1:0]            map_level;
  logic [OFF_W-1:0]            map_off;
  logic                        map_wr_en;
  logic [imhq_pkg::ID_W-1:0]   map_wr_addr;
  logic [CNT_W:0]              pos_g;
  logic [CNT_W:0]              child_idx;
  logic                        child_ok;
  logic                        right_exists;
  logic [LVL_W-1:0]            rd_level;
  logic [OFF_W-1:0]            rd_off;

  imhq_pkg::cell_req_t         req;
  logic [2*SW-1:0]             cell_pair [LEVELS];
  logic [2*SW-1:0]             mux_pair;
  logic [SW-1:0]               rd_slot;
  logic [imhq_pkg::ID_W-1:0]   slot_id;
  logic [KW-1:0]               slot_key;
  logic [SW-1:0]               left_slot;
  logic [SW-1:0]               right_slot;
  logic [SW-1:0]               ch_slot;
  logic                        pick_right;
  logic                        up_move;
  logic                        down_move;

  assign busy      = (state != imhq_pkg::S_IDLE);
  assign accept    = start && !busy;
  assign here      = present[item_id];
  assign limit_eff = (cap_limit < LIMIT_CAP) ? cap_limit : LIMIT_CAP;
  assign ins_ok    = !here && (item_count < limit_eff);

  // tail step forward / back, wrapping at row boundaries
  assign row_last       = (CNT_W'(1) << tail_level) - CNT_W'(1);
  assign dec_row        = (CNT_W'(1) << (tail_level - LVL_W'(1))) - CNT_W'(1);
  assign tail_inc_level = ({1'b0, tail_off} == row_last) ? tail_level + LVL_W'(1) : tail_level;
  assign tail_inc_off   = ({1'b0, tail_off} == row_last) ? '0 : tail_off + OFF_W'(1);
  assign tail_dec_level = (tail_off == '0) ? tail_level - LVL_W'(1) : tail_level;
  assign tail_dec_off   = (tail_off == '0) ? dec_row[OFF_W-1:0] : tail_off - OFF_W'(1);

  assign map_level = map_rd_data[imhq_pkg::MAP_W-1:OFF_W];
  assign map_off   = map_rd_data[OFF_W-1:0];

  // children of the cursor: global index 2*pos+1 and 2*pos+2
  assign pos_g        = ((CNT_W+1)'(1) << cur_level) - (CNT_W+1)'(1) + (CNT_W+1)'(cur_off);
  assign child_idx    = {pos_g[CNT_W-1:0], 1'b1};
  assign child_ok     = child_idx < {1'b0, item_count};
  assign right_exists = (child_idx + (CNT_W+1)'(1)) < {1'b0, item_count};

  // read data from the level last addressed
  always_comb begin
    mux_pair = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if (rdq_level == LVL_W'(l)) begin
        mux_pair = cell_pair[l];
      end
    end
  end

  assign rd_slot    = rdq_bank ? mux_pair[2*SW-1:SW] : mux_pair[SW-1:0];
  assign slot_id    = rd_slot[SW-1:KW];
  assign slot_key   = rd_slot[KW-1:0];
  assign left_slot  = mux_pair[SW-1:0];
  assign right_slot = mux_pair[2*SW-1:SW];
  // equal children: left wins
  assign pick_right = right_ok && (left_slot[KW-1:0] > right_slot[KW-1:0]);
  assign ch_slot    = pick_right ? right_slot : left_slot;
  assign up_move    = tok_key < slot_key;
  assign down_move  = tok_key > ch_slot[KW-1:0];

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_next  = state;
    req         = '0;
    rd_level    = '0;
    rd_off      = '0;
    map_wr_en   = 1'b0;
    map_wr_addr = tok_id;
    // every heap write lands at the cursor
    req.wr_level = cur_level;
    req.wr_pair  = cur_off[OFF_W-1:1];
    req.wr_bank  = cur_off[0];
    req.wr_src   = imhq_pkg::SRC_TOKEN;
    case (state)
      imhq_pkg::S_IDLE: begin
        if (accept) begin
          case (imhq_pkg::op_t'(op))
            imhq_pkg::OP_INSERT: begin
              state_next = ins_ok ? imhq_pkg::S_UP_RD : imhq_pkg::S_ROOT_RD;
            end
            imhq_pkg::OP_REMOVE, imhq_pkg::OP_CHANGE: begin
              state_next = here ? imhq_pkg::S_MAP_DATA : imhq_pkg::S_ROOT_RD;
            end
            default: begin
              state_next = imhq_pkg::S_ROOT_RD;
            end
          endcase
        end
      end
      imhq_pkg::S_MAP_DATA: begin
        req.rd_en = 1'b1;
        if (op_q == imhq_pkg::OP_REMOVE) begin
          // pull the last item; nothing to do if it is the one removed
          rd_level = tail_dec_level;
          rd_off   = tail_dec_off;
          if (map_level == tail_dec_level && map_off == tail_dec_off) begin
            state_next = imhq_pkg::S_ROOT_RD;
          end else begin
            state_next = imhq_pkg::S_LAST_DATA;
          end
        end else begin
          rd_level   = map_level;
          rd_off     = map_off;
          state_next = imhq_pkg::S_OLD_DATA;
        end
      end
      imhq_pkg::S_LAST_DATA: begin
        state_next = imhq_pkg::S_UP_RD;
      end
      imhq_pkg::S_OLD_DATA: begin
        state_next = up_move ? imhq_pkg::S_UP_RD : imhq_pkg::S_DOWN_RD;
      end
      imhq_pkg::S_UP_RD: begin
        if (cur_level == '0) begin
          state_next = fallback ? imhq_pkg::S_DOWN_RD : imhq_pkg::S_PLACE;
        end else begin
          req.rd_en  = 1'b1;
          rd_level   = cur_level - LVL_W'(1);
          rd_off     = {1'b0, cur_off[OFF_W-1:1]};
          state_next = imhq_pkg::S_UP_CMP;
        end
      end
      imhq_pkg::S_UP_CMP: begin
        if (up_move) begin
          req.wr_en    = 1'b1;
          req.wr_src   = imhq_pkg::SRC_ABOVE;
          req.nb_bank  = rdq_bank;
          map_wr_en    = 1'b1;
          map_wr_addr  = slot_id;
          state_next   = imhq_pkg::S_UP_RD;
        end else begin
          state_next = fallback ? imhq_pkg::S_DOWN_RD : imhq_pkg::S_PLACE;
        end
      end
      imhq_pkg::S_DOWN_RD: begin
        if (child_ok) begin
          req.rd_en  = 1'b1;
          rd_level   = cur_level + LVL_W'(1);
          rd_off     = {cur_off[OFF_W-2:0], 1'b0};
          state_next = imhq_pkg::S_DOWN_CMP;
        end else begin
          state_next = imhq_pkg::S_PLACE;
        end
      end
      imhq_pkg::S_DOWN_CMP: begin
        if (down_move) begin
          req.wr_en   = 1'b1;
          req.wr_src  = imhq_pkg::SRC_BELOW;
          req.nb_bank = pick_right;
          map_wr_en   = 1'b1;
          map_wr_addr = ch_slot[SW-1:KW];
          state_next  = imhq_pkg::S_DOWN_RD;
        end else begin
          state_next = imhq_pkg::S_PLACE;
        end
      end
      imhq_pkg::S_PLACE: begin
        req.wr_en  = 1'b1;
        map_wr_en  = 1'b1;
        state_next = imhq_pkg::S_ROOT_RD;
      end
      imhq_pkg::S_ROOT_RD: begin
        req.rd_en  = 1'b1;
        state_next = imhq_pkg::S_ROOT_DATA;
      end
      imhq_pkg::S_ROOT_DATA: begin
        state_next = imhq_pkg::S_IDLE;
      end
      default: begin
        state_next = imhq_pkg::S_IDLE;
      end
    endcase
    req.rd_level = rd_level;
    req.rd_pair  = rd_off[OFF_W-1:1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= imhq_pkg::S_IDLE;
      item_count <= '0;
      tail_level <= '0;
      tail_off   <= '0;
      present    <= '0;
      cap_limit  <= CNT_W'(256);
      done       <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (cfg_wr_en) begin
        cap_limit <= cfg_wr_data;
      end
      if (req.rd_en) begin
        rdq_level <= rd_level;
        rdq_bank  <= rd_off[0];
      end
      case (state)
        imhq_pkg::S_IDLE: begin
          if (accept) begin
            op_q     <= imhq_pkg::op_t'(op);
            tok_id   <= item_id;
            tok_key  <= key[KW-1:0];
            fallback <= 1'b0;
            case (imhq_pkg::op_t'(op))
              imhq_pkg::OP_INSERT: begin
                if (here) begin
                  status_q <= imhq_pkg::ST_DUP;
                end else if (!ins_ok) begin
                  status_q <= imhq_pkg::ST_FULL;
                end else begin
                  status_q         <= imhq_pkg::ST_OK;
                  present[item_id] <= 1'b1;
                  item_count       <= item_count + CNT_W'(1);
                  cur_level        <= tail_level;
                  cur_off          <= tail_off;
                  tail_level       <= tail_inc_level;
                  tail_off         <= tail_inc_off;
                end
              end
              imhq_pkg::OP_REMOVE, imhq_pkg::OP_CHANGE: begin
                status_q <= here ? imhq_pkg::ST_OK : imhq_pkg::ST_ABSENT;
              end
              default: begin
                status_q <= (item_count == '0) ? imhq_pkg::ST_EMPTY : imhq_pkg::ST_OK;
              end
            endcase
          end
        end
        imhq_pkg::S_MAP_DATA: begin
          cur_level <= map_level;
          cur_off   <= map_off;
          if (op_q == imhq_pkg::OP_REMOVE) begin
            present[tok_id] <= 1'b0;
            item_count      <= item_count - CNT_W'(1);
            tail_level      <= tail_dec_level;
            tail_off        <= tail_dec_off;
          end
        end
        imhq_pkg::S_LAST_DATA: begin
          // last item becomes the token, re-settled from the freed slot
          tok_id   <= slot_id;
          tok_key  <= slot_key;
          fallback <= 1'b1;
        end
        imhq_pkg::S_UP_CMP: begin
          if (up_move) begin
            cur_level <= cur_level - LVL_W'(1);
            cur_off   <= {1'b0, cur_off[OFF_W-1:1]};
            fallback  <= 1'b0;
          end
        end
        imhq_pkg::S_DOWN_RD: begin
          right_ok <= right_exists;
        end
        imhq_pkg::S_DOWN_CMP: begin
          if (down_move) begin
            cur_level <= cur_level + LVL_W'(1);
            cur_off   <= {cur_off[OFF_W-2:0], pick_right};
          end
        end
        imhq_pkg::S_ROOT_DATA: begin
          status    <= status_q;
          top_valid <= (item_count != '0);
          top_item  <= (item_count != '0) ? slot_id : '0;
          top_key   <= (item_count != '0) ? 32'(slot_key) : '0;
          count     <= item_count;
          done      <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- storage
  imhq_ram #(.WIDTH(imhq_pkg::MAP_W), .DEPTH(imhq_pkg::ID_SPACE)) u_map (
    .clk     (clk),
    .wr_en   (map_wr_en),
    .wr_addr (map_wr_addr),
    .wr_data ({cur_level, cur_off}),
    .rd_en   (accept),
    .rd_addr (item_id),
    .rd_data (map_rd_data)
  );

  // one cell per heap level, each wired to the level above and below
  for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
    logic [2*SW-1:0] above;
    logic [2*SW-1:0] below;
    if (l == 0) begin : g_top
      assign above = '0;
    end else begin : g_mid_a
      assign above = cell_pair[l-1];
    end
    if (l == LEVELS - 1) begin : g_bot
      assign below = '0;
    end else begin : g_mid_b
      assign below = cell_pair[l+1];
    end
    imhq_cell #(.LEVEL(l), .PAIRS(level_pairs(l)), .KEY_W(KW)) u_cell (
      .clk        (clk),
      .req        (req),
      .token_id   (tok_id),
      .token_key  (tok_key),
      .above_pair (above),
      .below_pair (below),
      .pair_out   (cell_pair[l])
    );
  end

  // ---------------------------------------------------------------- checks
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done strobe held more than one cycle");

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("request accepted but block not busy");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    item_count <= CNT_W'(HEAP_DEPTH)) else $error("item count beyond heap depth");

  a_tail_tracks_count: assert property (@(posedge clk) disable iff (rst)
    (item_count == '0) |-> (tail_level == '0 && tail_off == '0))
    else $error("tail cursor out of step with item count");

  a_top_matches_count: assert property (@(posedge clk) disable iff (rst)
    done |-> (top_valid == (count != '0))) else $error("top_valid disagrees with count");

endmodule

`default_nettype wire

[verif/indexed_min_heap_queue_unit_tb.sv]
// Self-checking testbench for the indexed min-heap queue unit.
module indexed_min_heap_queue_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import imhq_pkg::*;

  localparam int HEAP_DEPTH  = MAX_DEPTH;
  localparam int QUIET_LIMIT = 2000;  // cycles with no request or result taken
  localparam int TAIL_CYCLES = 40;    // idle stretch after the final drain

  // One predicted result per request.
  typedef struct {
    op_t         op;
    status_t     status;
    logic        top_valid;
    logic [7:0]  top_item;
    logic [31:0] top_key;
    logic [8:0]  count;
  } heap_result_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  op;
  logic [7:0]  item_id;
  logic [31:0] key;
  logic        done;
  logic [2:0]  status;
  logic        top_valid;
  logic [7:0]  top_item;
  logic [31:0] top_key;
  logic [8:0]  count;
  logic        cfg_wr_en;
  logic [8:0]  cfg_wr_data;

  indexed_min_heap_queue_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .op          (op),
    .item_id     (item_id),
    .key         (key),
    .done        (done),
    .status      (status),
    .top_valid   (top_valid),
    .top_item    (top_item),
    .top_key     (top_key),
    .count       (count),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Shadow heap: slot arrays, id -> slot map, presence bits, fill count.
  logic [7:0]   slot_item [HEAP_DEPTH];
  logic [31:0]  slot_key  [HEAP_DEPTH];
  int unsigned  item_slot [ID_SPACE];
  bit           item_held [ID_SPACE];
  int unsigned  held_count = 0;
  logic [8:0]   cap_reg    = 9'd256;

  heap_result_t awaited_results [$];
  heap_result_t front_result;
  int           mismatch_count = 0;
  int           quiet_cycles   = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow heap model
  // ---------------------------------------------------------------------------
  function automatic void put_entry(int unsigned p, logic [7:0] id, logic [31:0] k);
    slot_item[p]  = id;
    slot_key[p]   = k;
    item_slot[id] = p;
  endfunction

  // Move up while strictly smaller than the parent.
  function automatic void bubble_up(int unsigned p);
    logic [7:0]  id;
    logic [31:0] k;
    int unsigned par;
    bit          moving;
    id     = slot_item[p];
    k      = slot_key[p];
    moving = 1'b1;
    while (moving && p > 0) begin
      par = (p - 1) / 2;
      if (!(k < slot_key[par])) begin
        moving = 1'b0;
      end else begin
        put_entry(p, slot_item[par], slot_key[par]);
        p = par;
      end
    end
    put_entry(p, id, k);
  endfunction

  // Move down; left child wins ties, stop when not larger than the child.
  function automatic void sink_down(int unsigned p);
    logic [7:0]  id;
    logic [31:0] k;
    int unsigned c;
    bit          moving;
    id     = slot_item[p];
    k      = slot_key[p];
    moving = 1'b1;
    while (moving) begin
      c = 2 * p + 1;
      if (c >= held_count) begin
        moving = 1'b0;
      end else begin
        if (c + 1 < held_count && slot_key[c] > slot_key[c + 1]) c = c + 1;
        if (k <= slot_key[c]) begin
          moving = 1'b0;
        end else begin
          put_entry(p, slot_item[c], slot_key[c]);
          p = c;
        end
      end
    end
    put_entry(p, id, k);
  endfunction

  // Update the shadow heap for one request and return what the unit reports.
  function automatic heap_result_t apply_request(op_t o, logic [7:0] id, logic [31:0] k);
    heap_result_t r;
    int unsigned  lim;
    int unsigned  p;
    int unsigned  last;
    logic [31:0]  old_key;
    bit           here;
    lim    = (cap_reg < HEAP_DEPTH) ? cap_reg : HEAP_DEPTH;
    here   = item_held[id] && (item_slot[id] < held_count);
    r.op     = o;
    r.status = ST_OK;
    case (o)
      OP_INSERT: begin
        // duplicate is reported ahead of a full heap
        if (here) begin
          r.status = ST_DUP;
        end else if (held_count >= lim) begin
          r.status = ST_FULL;
        end else begin
          put_entry(held_count, id, k);
          item_held[id] = 1'b1;
          held_count    = held_count + 1;
          bubble_up(held_count - 1);
        end
      end
      OP_REMOVE: begin
        if (!here) begin
          r.status = ST_ABSENT;
        end else begin
          p             = item_slot[id];
          last          = held_count - 1;
          item_held[id] = 1'b0;
          held_count    = last;
          // last entry fills the hole, then settles either way
          if (p != last) begin
            put_entry(p, slot_item[last], slot_key[last]);
            if (p > 0 && slot_key[p] < slot_key[(p - 1) / 2]) bubble_up(p);
            else sink_down(p);
          end
        end
      end
      OP_CHANGE: begin
        if (!here) begin
          r.status = ST_ABSENT;
        end else begin
          p           = item_slot[id];
          old_key     = slot_key[p];
          slot_key[p] = k;
          if (k < old_key) bubble_up(p);
          else sink_down(p);
        end
      end
      default: begin
        if (held_count == 0) r.status = ST_EMPTY;
      end
    endcase
    r.top_valid = (held_count > 0);
    r.top_item  = (held_count > 0) ? slot_item[0] : 8'd0;
    r.top_key   = (held_count > 0) ? slot_key[0] : 32'd0;
    r.count     = held_count[8:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side: drive at the falling edge, take the handshake at the rising
  // edge. start is left high after acceptance; the next call or an idle
  // stretch decides its next value, so it never gets two writes in one step.
  // ---------------------------------------------------------------------------
  task automatic issue_request(op_t o, logic [7:0] id, logic [31:0] k);
    @(negedge clk);
    start   = 1'b1;
    op      = o;
    item_id = id;
    key     = k;
    @(posedge clk);
    while (busy) @(posedge clk);
    awaited_results.push_back(apply_request(o, id, k));
  endtask

  task automatic idle_for(int n);
    repeat (n) begin
      @(negedge clk);
      start = 1'b0;
    end
  endtask

  // Hold off until every result is back and the unit is idle.
  task automatic wait_for_drain();
    @(negedge clk);
    start = 1'b0;
    while (awaited_results.size() != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Capacity writes only happen with the unit drained.
  task automatic write_capacity(logic [8:0] value);
    wait_for_drain();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(posedge clk);
    cap_reg = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Mostly well-formed traffic: remove/re-key target live items, keys mix
  // extremes, tiny values and ties with the current minimum.
  task automatic send_random(int ins_pct);
    int          r;
    int          rest;
    op_t         o;
    logic [7:0]  id;
    logic [31:0] k;
    r    = $urandom_range(99);
    rest = 100 - ins_pct;
    if (r < ins_pct) o = OP_INSERT;
    else if (r < ins_pct + rest * 2 / 5) o = OP_REMOVE;
    else if (r < ins_pct + rest * 4 / 5) o = OP_CHANGE;
    else o = OP_PEEK;
    if (o != OP_INSERT && held_count > 0 && $urandom_range(99) < 85)
      id = slot_item[$urandom_range(held_count - 1)];
    else
      id = $urandom;
    case ($urandom_range(9))
      0:       k = '0;
      1:       k = '1;
      2, 3:    k = $urandom_range(15);
      4:       k = (held_count > 0) ? slot_key[0] : $urandom;
      default: k = $urandom;
    endcase
    issue_request(o, id, k);
  endtask

  task automatic run_random(int n, int ins_pct, bit gaps);
    repeat (n) begin
      if (gaps && $urandom_range(99) < 7) idle_for($urandom_range(30, 1));
      if (gaps && $urandom_range(199) == 0) wait_for_drain();
      send_random(ins_pct);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Fresh heap: peek reports empty, remove/re-key report absent.
  task automatic test_empty_heap();
    issue_request(OP_PEEK, 8'd0, 32'd0);
    issue_request(OP_REMOVE, 8'd7, 32'd0);
    issue_request(OP_CHANGE, 8'd7, 32'h1234);
  endtask

  // Id and key extremes, new minimum, duplicate, equal-key tie.
  task automatic test_insert_order();
    issue_request(OP_INSERT, 8'd0, 32'h0000_0100);
    issue_request(OP_INSERT, 8'd255, 32'hFFFF_FFFF);
    issue_request(OP_INSERT, 8'd128, 32'd0);
    issue_request(OP_INSERT, 8'd0, 32'd5);
    issue_request(OP_INSERT, 8'd5, 32'd0);
    issue_request(OP_PEEK, 8'd0, 32'd0);
  endtask

  // Smaller key sifts up, larger sifts down, equal key stays put.
  task automatic test_rekey();
    issue_request(OP_CHANGE, 8'd255, 32'd0);
    issue_request(OP_CHANGE, 8'd128, 32'hFFFF_FFFF);
    issue_request(OP_CHANGE, 8'd5, 32'd0);
    issue_request(OP_CHANGE, 8'd0, 32'h0000_0100);
  endtask

  // Remove the root, the last slot, then empty the heap.
  task automatic test_remove();
    issue_request(OP_REMOVE, slot_item[0], 32'd0);
    issue_request(OP_REMOVE, slot_item[held_count - 1], 32'd0);
    while (held_count > 0) issue_request(OP_REMOVE, slot_item[0], 32'd0);
    issue_request(OP_PEEK, 8'd0, 32'd0);
  endtask

  // Limit of one, zero (refuses all inserts), and above the depth.
  task automatic test_capacity();
    write_capacity(9'd1);
    issue_request(OP_INSERT, 8'd10, 32'd40);
    issue_request(OP_INSERT, 8'd11, 32'd20);
    issue_request(OP_INSERT, 8'd10, 32'd30);
    write_capacity(9'd0);
    issue_request(OP_INSERT, 8'd12, 32'd1);
    issue_request(OP_REMOVE, 8'd10, 32'd0);
    issue_request(OP_INSERT, 8'd10, 32'd1);
    write_capacity(9'h1FF);
    issue_request(OP_INSERT, 8'd12, 32'd1);
    issue_request(OP_REMOVE, 8'd12, 32'd0);
  endtask

  // Balanced traffic at the reset limit; first half back to back.
  task automatic test_random_mix();
    write_capacity(9'd256);
    run_random(150, 55, 1'b0);
    run_random(150, 55, 1'b1);
  endtask

  // Insert-heavy with the limit above the depth, so the heap fills up.
  task automatic test_fill_to_full();
    write_capacity(9'h1FF);
    run_random(250, 90, 1'b1);
  endtask

  // Remove live items at random positions until the heap is empty.
  task automatic test_drain_heap();
    while (held_count > 0) begin
      if ($urandom_range(99) < 7) idle_for($urandom_range(30, 1));
      issue_request(OP_REMOVE, slot_item[$urandom_range(held_count - 1)], $urandom);
    end
  endtask

  // Small limits where full refusals and empty peeks are common.
  task automatic test_tight_limit();
    write_capacity(9'd2);
    run_random(60, 50, 1'b1);
    write_capacity(9'd5);
    run_random(60, 50, 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Result check: done is a one-cycle strobe, sampled at the rising edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("[%0t] result with no request waiting: st=%0d item=%0d key=%h cnt=%0d",
                   $realtime, status, top_item, top_key, count);
      end else begin
        front_result = awaited_results.pop_front();
        if (status !== front_result.status || top_valid !== front_result.top_valid ||
            top_item !== front_result.top_item || top_key !== front_result.top_key ||
            count !== front_result.count) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("[%0t] %s mismatch: exp st=%0d v=%0d item=%0d key=%h cnt=%0d",
                     $realtime, front_result.op.name(), front_result.status,
                     front_result.top_valid, front_result.top_item,
                     front_result.top_key, front_result.count,
                     " got st=%0d v=%0d item=%0d key=%h cnt=%0d",
                     status, top_valid, top_item, top_key, count);
        end
      end
    end
  end

  // Watchdog: count cycles where neither a request nor a result moves.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    op          = OP_PEEK;
    item_id     = '0;
    key         = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_heap();
    test_insert_order();
    test_rekey();
    test_remove();
    test_capacity();
    test_random_mix();
    test_fill_to_full();
    test_drain_heap();
    test_tight_limit();

    wait_for_drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
